@@ rtl/stall_lost_step_detector_assert.svh @@
// Assertion macros shared by the stall detector RTL.
// Needs only a clock and an active-low reset in the using module.
`ifndef STALL_LOST_STEP_DETECTOR_ASSERT_SVH
`define STALL_LOST_STEP_DETECTOR_ASSERT_SVH

// same-cycle implication
`define SLD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("stall detector assertion failed");

// next-cycle implication
`define SLD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("stall detector assertion failed");

`endif

@@ rtl/sld_pkg.sv @@
// Shared constants, register codes and stage word types of the stall detector.
// No dependencies.
package sld_pkg;

    localparam int WINDOW_DEF = 3;

    localparam int CFG_ADDR_W  = 5;
    localparam int S_TDATA_W   = 96;
    localparam int M_TDATA_W   = 40;

    localparam logic [2:0] REG_CHECK_INTERVAL    = 3'd0;
    localparam logic [2:0] REG_MOVE_THRESHOLD    = 3'd1;
    localparam logic [2:0] REG_SUPPRESS_INTERVAL = 3'd2;
    localparam logic [2:0] REG_EDGE_MARGIN       = 3'd3;
    localparam logic [2:0] REG_BOTTOM_LIMIT      = 3'd4;

    localparam logic [31:0] CHECK_INTERVAL_RST    = 32'd1000;
    localparam logic [31:0] MOVE_THRESHOLD_RST    = 32'd2;
    localparam logic [31:0] SUPPRESS_INTERVAL_RST = 32'd1000;
    localparam logic [29:0] EDGE_MARGIN_RST       = 30'd1000;
    localparam logic [30:0] BOTTOM_LIMIT_RST      = 31'd0;

    typedef struct packed {
        logic        clr;
        logic        store;
        logic        full;
        logic        in_band;
        logic [31:0] now;
        logic [31:0] d_new;
        logic [31:0] d_out;
    } stage1_t;

    typedef struct packed {
        logic        clr;
        logic        checked;
        logic        in_band;
        logic [31:0] now;
        logic [31:0] total;
    } stage2_t;

endpackage

@@ rtl/sld_cell.sv @@
// One window cell: holds a sample position and its distance to the next older one.
// Standalone, no package use.
module sld_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               shift,
    input  logic signed [31:0] pos_in,
    output logic signed [31:0] pos_out,
    output logic        [31:0] diff_next,
    output logic        [31:0] diff_out
);

    logic signed [31:0] pos_reg;
    logic        [31:0] diff_reg;
    logic signed [32:0] delta;

    assign delta     = {pos_in[31], pos_in} - {pos_reg[31], pos_reg};
    assign diff_next = delta[32] ? 32'(-delta) : delta[31:0];
    assign pos_out   = pos_reg;
    assign diff_out  = diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            diff_reg <= '0;
        end else if (shift) begin
            pos_reg  <= pos_in;
            diff_reg <= diff_next;
        end
    end

endmodule

@@ rtl/sld_accum.sv @@
// Running window sum stage: adds the newest distance, drops the oldest, saturates.
// Depends on sld_pkg.
module sld_accum #(
    parameter int WINDOW = sld_pkg::WINDOW_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sld_pkg::stage1_t in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output sld_pkg::stage2_t out_word
);

    localparam int SUM_W = 32 + $clog2(WINDOW);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             valid_reg;
    sld_pkg::stage2_t word_reg;
    logic             take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        sum_next = sum_reg;
        if (in_word.store) begin
            sum_next = sum_reg + SUM_W'(in_word.d_new) - SUM_W'(in_word.d_out);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
        end else if (take) begin
            valid_reg <= 1'b1;
            sum_reg   <= sum_next;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            word_reg.clr     <= in_word.clr;
            word_reg.checked <= in_word.full;
            word_reg.in_band <= in_word.in_band;
            word_reg.now     <= in_word.now;
            word_reg.total   <= (|sum_next[SUM_W-1:32]) ? 32'hFFFF_FFFF : sum_next[31:0];
        end
    end

endmodule

@@ rtl/sld_alarm.sv @@
// Alarm decision with hold-off timer and the output word register.
// Depends on sld_pkg.
module sld_alarm (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sld_pkg::stage2_t              in_word,
    input  logic [31:0]                   move_threshold,
    input  logic [31:0]                   suppress_interval,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sld_pkg::M_TDATA_W-1:0] m_tdata
);

    logic        valid_reg;
    logic [sld_pkg::M_TDATA_W-1:0] data_reg;
    logic [31:0] last_alarm_reg;
    logic [31:0] since_alarm;
    logic        alarm;
    logic        take;

    assign in_ready    = !valid_reg || m_tready;
    assign take        = in_valid && in_ready;
    assign since_alarm = in_word.now - last_alarm_reg;
    assign alarm       = in_word.checked && (in_word.total < move_threshold) &&
                         in_word.in_band && (since_alarm >= suppress_interval);
    assign m_tvalid    = valid_reg;
    assign m_tdata     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            last_alarm_reg <= '0;
        end else begin
            if (take) begin
                valid_reg <= 1'b1;
                if (in_word.clr) begin
                    last_alarm_reg <= '0;
                end else if (alarm) begin
                    last_alarm_reg <= in_word.now;
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= {6'b0, (in_word.checked ? in_word.total : 32'd0),
                         in_word.checked, alarm};
        end
    end

endmodule

@@ rtl/stall_lost_step_detector.sv @@
// Stall (lost-step) detector: sample gate, window cell chain, running sum and alarm.
// Depends on sld_pkg, sld_cell, sld_accum, sld_alarm and the assertion header.
//
// Takes one word per clock while the output is not stalled and returns one result
// word per input word. The first stage gates samples on the check interval and
// shifts the row of WINDOW-1 cells, each of which holds one sample and its
// distance to the next older one; the second stage keeps a running window sum
// (newest distance in, oldest out); the third applies the threshold, cable band
// and alarm hold-off. The user must write configuration through the APB port only
// while no word is in flight; the block itself does not enforce this.
module stall_lost_step_detector #(
    parameter int WINDOW = sld_pkg::WINDOW_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: now_ms[31:0], position[63:32], cable_len[95:64]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sld_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: func (1 = restart)
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: lost_step[0], checked[1], move_sum[33:2], zero fill
    output logic [sld_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sld_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    `include "stall_lost_step_detector_assert.svh"

    localparam int NCELL = WINDOW - 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

    logic [31:0] check_interval_reg;
    logic [31:0] move_threshold_reg;
    logic [31:0] suppress_interval_reg;
    logic [29:0] edge_margin_reg;
    logic [30:0] bottom_limit_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [31:0]      last_check_reg;
    logic             p1_valid_reg;
    sld_pkg::stage1_t p1_reg;

    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic               accept;
    logic [31:0]        now_ms;
    logic signed [31:0] position;
    logic signed [31:0] cable_len;
    logic [31:0]        elapsed;
    logic               early;
    logic               store;
    logic signed [33:0] cable_x;
    logic signed [33:0] margin_x;
    logic signed [33:0] upper_x;
    logic               in_band;
    logic [31:0]        d_new;

    logic signed [31:0] pos_chain  [NCELL];
    logic        [31:0] diff_chain [NCELL];

    logic             acc_ready;
    logic             p2_valid;
    logic             p2_ready;
    sld_pkg::stage2_t p2_word;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_interval_reg    <= sld_pkg::CHECK_INTERVAL_RST;
            move_threshold_reg    <= sld_pkg::MOVE_THRESHOLD_RST;
            suppress_interval_reg <= sld_pkg::SUPPRESS_INTERVAL_RST;
            edge_margin_reg       <= sld_pkg::EDGE_MARGIN_RST;
            bottom_limit_reg      <= sld_pkg::BOTTOM_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sld_pkg::REG_CHECK_INTERVAL:    check_interval_reg    <= pwdata;
                sld_pkg::REG_MOVE_THRESHOLD:    move_threshold_reg    <= pwdata;
                sld_pkg::REG_SUPPRESS_INTERVAL: suppress_interval_reg <= pwdata;
                sld_pkg::REG_EDGE_MARGIN:       edge_margin_reg       <= pwdata[29:0];
                sld_pkg::REG_BOTTOM_LIMIT:      bottom_limit_reg      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            sld_pkg::REG_CHECK_INTERVAL:    prdata = check_interval_reg;
            sld_pkg::REG_MOVE_THRESHOLD:    prdata = move_threshold_reg;
            sld_pkg::REG_SUPPRESS_INTERVAL: prdata = suppress_interval_reg;
            sld_pkg::REG_EDGE_MARGIN:       prdata = {2'b0, edge_margin_reg};
            sld_pkg::REG_BOTTOM_LIMIT:      prdata = {1'b0, bottom_limit_reg};
            default:                        prdata = '0;
        endcase
    end

    assign now_ms    = s_tdata[31:0];
    assign position  = s_tdata[63:32];
    assign cable_len = s_tdata[95:64];

    assign s_tready = !p1_valid_reg || acc_ready;
    assign accept   = s_tvalid && s_tready;
    assign elapsed  = now_ms - last_check_reg;
    assign early    = elapsed < check_interval_reg;
    assign store    = accept && !s_tuser && !early;
    assign cnt_next = (cnt_reg == WIN_CNT) ? cnt_reg : cnt_reg + CNT_W'(1);

    assign cable_x  = {{2{cable_len[31]}}, cable_len};
    assign margin_x = {4'b0, edge_margin_reg};
    assign upper_x  = {{3{bottom_limit_reg[30]}}, bottom_limit_reg} - margin_x;
    assign in_band  = (cable_x > margin_x) && (cable_x < upper_x);

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        if (i == 0) begin : g_head
            sld_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift     (store),
                .pos_in    (position),
                .pos_out   (pos_chain[i]),
                .diff_next (d_new),
                .diff_out  (diff_chain[i])
            );
        end else begin : g_body
            sld_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift     (store),
                .pos_in    (pos_chain[i-1]),
                .pos_out   (pos_chain[i]),
                .diff_next (),
                .diff_out  (diff_chain[i])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            last_check_reg <= '0;
            p1_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
                if (s_tuser) begin
                    cnt_reg        <= '0;
                    last_check_reg <= '0;
                end else if (!early) begin
                    cnt_reg        <= cnt_next;
                    last_check_reg <= now_ms;
                end
            end else if (acc_ready) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg.clr     <= s_tuser;
            p1_reg.store   <= store;
            p1_reg.full    <= store && (cnt_next == WIN_CNT);
            p1_reg.in_band <= in_band;
            p1_reg.now     <= now_ms;
            p1_reg.d_new   <= d_new;
            p1_reg.d_out   <= diff_chain[NCELL-1];
        end
    end

    sld_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p1_valid_reg),
        .in_ready  (acc_ready),
        .in_word   (p1_reg),
        .out_valid (p2_valid),
        .out_ready (p2_ready),
        .out_word  (p2_word)
    );

    sld_alarm u_alarm (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (p2_valid),
        .in_ready          (p2_ready),
        .in_word           (p2_word),
        .move_threshold    (move_threshold_reg),
        .suppress_interval (suppress_interval_reg),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

    `SLD_ASSERT_IMP(a_alarm_needs_check, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[1])
    `SLD_ASSERT_IMP(a_idle_total_zero, aclk, aresetn, m_tvalid && !m_tdata[1], m_tdata[33:2] == 32'd0)
    `SLD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, cnt_reg <= WIN_CNT)
    `SLD_ASSERT_NEXT(a_restart_clears, aclk, aresetn, accept && s_tuser, cnt_reg == '0 && last_check_reg == 32'd0)

endmodule

@@ tb/tb_stall_lost_step_detector.sv @@
// Testbench for the stall (lost-step) detector: directed window and alarm band cases,
// then random sample streams under four idle patterns, checked against a local predictor.
// Depends on sld_pkg and the stall_lost_step_detector RTL.
module tb_stall_lost_step_detector;

    localparam int     CYCLE_LIMIT = 400000;
    localparam longint SUM_MAX     = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic        lost;
        logic        checked;
        logic [31:0] total;
    } stall_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [sld_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [sld_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sld_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    stall_lost_step_detector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of registers and detector state
    logic [31:0]        chk_int;
    logic [31:0]        move_thr;
    logic [31:0]        supp_int;
    logic [29:0]        edge_mgn;
    logic signed [30:0] bottom_lim;
    logic [31:0]        pos_ring [sld_pkg::WINDOW_DEF];
    int                 ring_wr;
    int                 ring_fill;
    logic [31:0]        last_chk_ms;
    logic [31:0]        last_alarm_ms;

    stall_result_t pending_results [$];
    int            mismatches;
    int            cycle_count;
    int            src_idle_pct;
    int            snk_stall_pct;
    logic [31:0]   walk_pos;

    function automatic void clear_window();
        for (int i = 0; i < sld_pkg::WINDOW_DEF; i++) pos_ring[i] = '0;
        ring_wr       = 0;
        ring_fill     = 0;
        last_chk_ms   = '0;
        last_alarm_ms = '0;
    endfunction

    function automatic stall_result_t calc_stall_result(logic restart, logic [31:0] now,
                                                        logic [31:0] pos, logic [31:0] cab);
        stall_result_t res;
        logic [31:0]   since_chk;
        logic [31:0]   since_alarm;
        longint        total;
        longint        d;
        longint        cab_l;
        longint        lo;
        longint        hi;
        int            a;
        int            b;
        res = '0;
        if (restart) begin
            clear_window();
            return res;
        end
        since_chk = now - last_chk_ms;
        if (since_chk < chk_int) return res;
        last_chk_ms       = now;
        pos_ring[ring_wr] = pos;
        ring_wr           = (ring_wr + 1) % sld_pkg::WINDOW_DEF;
        if (ring_fill < sld_pkg::WINDOW_DEF) ring_fill++;
        if (ring_fill < sld_pkg::WINDOW_DEF) return res;
        total = 0;
        for (int k = 0; k + 1 < sld_pkg::WINDOW_DEF; k++) begin
            a = (ring_wr + k) % sld_pkg::WINDOW_DEF;
            b = (ring_wr + k + 1) % sld_pkg::WINDOW_DEF;
            d = longint'($signed(pos_ring[b])) - longint'($signed(pos_ring[a]));
            total += (d < 0) ? -d : d;
        end
        if (total > SUM_MAX) total = SUM_MAX;
        res.checked = 1'b1;
        res.total   = total[31:0];
        cab_l       = longint'($signed(cab));
        lo          = longint'(edge_mgn);
        hi          = longint'(bottom_lim) - lo;
        since_alarm = now - last_alarm_ms;
        if (total < longint'(move_thr) && cab_l > lo && cab_l < hi
            && since_alarm >= supp_int) begin
            last_alarm_ms = now;
            res.lost      = 1'b1;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stall_lost_step_detector test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        stall_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.lost || m_tdata[1] !== want.checked
                    || m_tdata[33:2] !== want.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: lost_step %b/%b checked %b/%b total %h/%h",
                                 want.lost, m_tdata[0], want.checked, m_tdata[1],
                                 want.total, m_tdata[33:2]);
                end
            end
        end
    end

    task automatic send_word(logic restart, logic [31:0] now, logic [31:0] pos,
                             logic [31:0] cab);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= {cab, pos, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(calc_stall_result(restart, now, pos, cab));
    endtask

    // hold input until every expected word is back and the pipeline has emptied
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_reg(logic [2:0] code, logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (code)
            sld_pkg::REG_CHECK_INTERVAL:    chk_int    = value;
            sld_pkg::REG_MOVE_THRESHOLD:    move_thr   = value;
            sld_pkg::REG_SUPPRESS_INTERVAL: supp_int   = value;
            sld_pkg::REG_EDGE_MARGIN:       edge_mgn   = value[29:0];
            sld_pkg::REG_BOTTOM_LIMIT:      bottom_lim = value[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(logic [31:0] chk, logic [31:0] thr, logic [31:0] supp,
                                 logic [31:0] edge_val, logic [31:0] bottom);
        set_reg(sld_pkg::REG_CHECK_INTERVAL, chk);
        set_reg(sld_pkg::REG_MOVE_THRESHOLD, thr);
        set_reg(sld_pkg::REG_SUPPRESS_INTERVAL, supp);
        set_reg(sld_pkg::REG_EDGE_MARGIN, edge_val);
        set_reg(sld_pkg::REG_BOTTOM_LIMIT, bottom);
    endtask

    task automatic reset_dut();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        chk_int    = sld_pkg::CHECK_INTERVAL_RST;
        move_thr   = sld_pkg::MOVE_THRESHOLD_RST;
        supp_int   = sld_pkg::SUPPRESS_INTERVAL_RST;
        edge_mgn   = sld_pkg::EDGE_MARGIN_RST;
        bottom_lim = sld_pkg::BOTTOM_LIMIT_RST;
        clear_window();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // reset registers: band is empty, so no alarm; covers saturation and tick wrap
    task automatic test_window_basics();
        send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b0, 32'd999, 32'd7, 32'd0);
        send_word(1'b0, 32'd1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(1'b0, 32'd2000, 32'h8000_0000, 32'h8000_0000);
        send_word(1'b0, 32'd3000, 32'h7FFF_FFFF, 32'd5000);
        send_word(1'b0, 32'd3999, 32'd0, 32'd5000);
        send_word(1'b0, 32'd4000, 32'h8000_0000, 32'd5000);
        send_word(1'b1, 32'd0, 32'd0, 32'd0);
        send_word(1'b0, 32'hFFFF_FFFF, 32'd5, 32'd5000);
        send_word(1'b0, 32'd999, 32'd5, 32'd5000);
        send_word(1'b0, 32'd1998, 32'd6, 32'd5000);
    endtask

    // band 1000 < cable < 9000: hold-off, both band edges, threshold edge
    task automatic test_alarm_band();
        apply_setting(32'd0, 32'd2, 32'd1000, 32'd1000, 32'd10000);
        send_word(1'b1, 32'd0, 32'd0, 32'd0);
        send_word(1'b0, 32'd0, 32'd100, 32'd5000);
        send_word(1'b0, 32'd0, 32'd100, 32'd5000);
        send_word(1'b0, 32'd0, 32'd101, 32'd5000);
        send_word(1'b0, 32'd1000, 32'd101, 32'd5000);
        send_word(1'b0, 32'd1500, 32'd101, 32'd5000);
        send_word(1'b0, 32'd2000, 32'd101, 32'd1000);
        send_word(1'b0, 32'd2100, 32'd101, 32'd9000);
        send_word(1'b0, 32'd2200, 32'd101, 32'd8999);
        send_word(1'b0, 32'd3300, 32'd102, 32'd1001);
        send_word(1'b0, 32'd4400, 32'd104, 32'd5000);
        send_word(1'b1, 32'd0, 32'd0, 32'd0);
    endtask

    task automatic send_random_word();
        int          sel;
        logic [31:0] cab;
        logic [31:0] step;
        longint      lo;
        longint      hi;
        sel = $urandom_range(99);
        lo  = longint'(edge_mgn) + 1;
        hi  = longint'(bottom_lim) - longint'(edge_mgn) - 1;
        if (hi >= lo && $urandom_range(9) < 8)
            cab = 32'(lo + longint'($urandom_range(32'(hi - lo))));
        else
            cab = $urandom;
        if ($urandom_range(9) == 0)
            walk_pos = $urandom;
        else
            walk_pos = walk_pos + 32'($urandom_range(6)) - 32'd3;
        if (sel < 5) begin
            send_word(1'b1, $urandom, $urandom, $urandom);
        end else if (sel < 15) begin
            send_word(1'b0, $urandom, $urandom, $urandom);
        end else if (sel < 25 && chk_int != 0) begin
            send_word(1'b0, last_chk_ms + $urandom_range(chk_int - 1), walk_pos, cab);
        end else begin
            if (chk_int > 32'hFFFF_FFF0)
                step = chk_int;
            else
                step = chk_int + $urandom_range(3);
            send_word(1'b0, last_chk_ms + step, walk_pos, cab);
        end
    endtask

    task automatic use_setting(int idx);
        case (idx)
            0: apply_setting(32'd1000, 32'd8, 32'd2500, 32'd1000, 32'd200000);
            1: apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'h3FFF_FFFF);
            2: apply_setting(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h3FFF_FFFF);
            3: apply_setting(32'hFFFF_FFFF, 32'd4, 32'hFFFF_FFFF, 32'h3FFF_FFFF,
                             32'hC000_0000);
            default: apply_setting($urandom_range(50), $urandom_range(16),
                                   $urandom_range(200), $urandom_range(5000),
                                   $urandom_range(1000000, 10000));
        endcase
    endtask

    task automatic test_random_traffic();
        int src_pcts [4] = '{0, 83, 0, 24};
        int snk_pcts [4] = '{0, 0, 83, 24};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = src_pcts[p];
            snk_stall_pct = snk_pcts[p];
            for (int s = 0; s < 2; s++) begin
                use_setting((2 * p + s) % 5);
                send_word(1'b1, $urandom, $urandom, $urandom);
                for (int n = 0; n < 100; n++) send_random_word();
            end
        end
    endtask

    initial begin
        mismatches    = 0;
        cycle_count   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        walk_pos      = '0;
        reset_dut();
        test_window_basics();
        test_alarm_band();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("stall_lost_step_detector test passed");
        else
            $display("stall_lost_step_detector test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sld_pkg.sv
rtl/sld_cell.sv
rtl/sld_accum.sv
rtl/sld_alarm.sv
rtl/stall_lost_step_detector.sv
tb/tb_stall_lost_step_detector.sv
